// ===== src/sads_pkg.sv =====
package sads_pkg;

  localparam int MaxLen = 256;
  localparam int SymbolBits = 8;
  localparam int MaxStates = 2 * MaxLen;
  localparam int NumSym = 1 << SymbolBits;
  localparam int StateW = $clog2(MaxStates);
  localparam int LenW = $clog2(MaxLen + 1);
  localparam int AddrW = StateW + SymbolBits;
  localparam int CountW = 16;
  localparam int TakenW = $clog2(MaxLen + 1);

  typedef enum logic [3:0] {
    OpNone,
    OpInit,
    OpNewCur,
    OpRdEdge,
    OpWalkAdd,
    OpReadQ,
    OpSetLinkQ,
    OpCloneInit,
    OpCopyRow,
    OpRedirect,
    OpFinish,
    OpClearRow
  } op_e;

  typedef struct packed {
    op_e op;
    logic [SymbolBits-1:0] sym;
  } cmd_t;

  typedef struct packed {
    logic edge_empty;
    logic edge_is_q;
    logic p_has_link;
    logic len_ok;
    logic copy_done;
    logic clear_done;
    logic full;
  } status_t;

endpackage

// ===== src/sads_datapath.sv =====
module sads_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sads_pkg::cmd_t      cmd_i,
  output sads_pkg::status_t   status_o,
  output logic [15:0]         total_o
);

  logic [sads_pkg::StateW-1:0] trans_mem [sads_pkg::MaxStates*sads_pkg::NumSym];
  logic [sads_pkg::StateW-1:0] link_mem [sads_pkg::MaxStates];
  logic                        lvalid_mem [sads_pkg::MaxStates];
  logic [sads_pkg::LenW-1:0]   len_mem [sads_pkg::MaxStates];
  logic [sads_pkg::LenW-1:0]   cnt_mem [sads_pkg::MaxStates];

  logic [sads_pkg::StateW-1:0] used_q, last_q, cur_q, p_q, q_q, n_q;
  logic [sads_pkg::StateW-1:0] edge_q;
  logic [sads_pkg::StateW-1:0] plink_q, qlink_q;
  logic                        plv_q, qlv_q;
  logic [sads_pkg::LenW-1:0]   plen_q, qlen_q, pcnt_q, qcnt_q;
  logic [sads_pkg::LenW-1:0]   curcnt_q, ncnt_q;
  logic [15:0]                 total_q;
  logic [sads_pkg::TakenW-1:0] taken_q;
  logic [sads_pkg::SymbolBits:0] col_q;
  logic [sads_pkg::StateW:0]   row_q;
  logic [sads_pkg::StateW-1:0] copy_q;
  logic                        copy_v_q;
  logic [sads_pkg::SymbolBits-1:0] copy_col_q;

  logic [sads_pkg::AddrW-1:0] p_addr;
  assign p_addr = {p_q, cmd_i.sym};

  assign status_o.edge_empty = (edge_q == '0);
  assign status_o.edge_is_q  = (edge_q == q_q);
  assign status_o.p_has_link = plv_q;
  assign status_o.len_ok     = (plen_q + 1'b1 == qlen_q);
  assign status_o.copy_done  = col_q[sads_pkg::SymbolBits] && !copy_v_q;
  assign status_o.clear_done = row_q[sads_pkg::StateW];
  assign status_o.full       = (taken_q == sads_pkg::TakenW'(sads_pkg::MaxLen));
  assign total_o = total_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sads_pkg::OpClearRow: begin
        trans_mem[{row_q[sads_pkg::StateW-1:0], col_q[sads_pkg::SymbolBits-1:0]}] <= '0;
      end
      sads_pkg::OpInit: begin
        link_mem[0] <= '0;
        lvalid_mem[0] <= 1'b0;
        len_mem[0] <= '0;
        cnt_mem[0] <= sads_pkg::LenW'(1);
      end
      sads_pkg::OpNewCur: begin
        len_mem[used_q] <= sads_pkg::LenW'(taken_q) + 1'b1;
        cnt_mem[used_q] <= '0;
        link_mem[used_q] <= '0;
        lvalid_mem[used_q] <= 1'b1;
      end
      sads_pkg::OpWalkAdd: begin
        cnt_mem[cur_q] <= curcnt_q + pcnt_q;
        trans_mem[p_addr] <= cur_q;
      end
      sads_pkg::OpSetLinkQ: link_mem[cur_q] <= q_q;
      sads_pkg::OpCloneInit: begin
        link_mem[used_q] <= qlink_q;
        lvalid_mem[used_q] <= qlv_q;
        len_mem[used_q] <= plen_q + 1'b1;
        cnt_mem[used_q] <= '0;
        link_mem[cur_q] <= used_q;
        link_mem[q_q] <= used_q;
        lvalid_mem[q_q] <= 1'b1;
      end
      sads_pkg::OpRedirect: begin
        cnt_mem[q_q] <= qcnt_q - pcnt_q;
        cnt_mem[n_q] <= ncnt_q + pcnt_q;
        trans_mem[p_addr] <= n_q;
      end
      default: begin
      end
    endcase
    if (copy_v_q) begin
      trans_mem[{n_q, copy_col_q}] <= copy_q;
    end
    copy_q <= trans_mem[{q_q, col_q[sads_pkg::SymbolBits-1:0]}];
    edge_q <= trans_mem[p_addr];
    plink_q <= link_mem[p_q];
    plv_q <= lvalid_mem[p_q];
    plen_q <= len_mem[p_q];
    pcnt_q <= cnt_mem[p_q];
    qlink_q <= link_mem[q_q];
    qlv_q <= lvalid_mem[q_q];
    qlen_q <= len_mem[q_q];
    qcnt_q <= cnt_mem[q_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= sads_pkg::StateW'(1);
      last_q <= '0;
      cur_q <= '0;
      p_q <= '0;
      q_q <= '0;
      n_q <= '0;
      curcnt_q <= '0;
      ncnt_q <= '0;
      total_q <= '0;
      taken_q <= '0;
      col_q <= '0;
      row_q <= '0;
      copy_v_q <= 1'b0;
      copy_col_q <= '0;
    end else begin
      copy_v_q <= (cmd_i.op == sads_pkg::OpCopyRow) && !col_q[sads_pkg::SymbolBits];
      case (cmd_i.op)
        sads_pkg::OpClearRow: begin
          if (col_q == (sads_pkg::SymbolBits+1)'(sads_pkg::NumSym - 1)) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        sads_pkg::OpNewCur: begin
          cur_q <= used_q;
          used_q <= used_q + 1'b1;
          p_q <= last_q;
          taken_q <= taken_q + 1'b1;
          curcnt_q <= '0;
        end
        sads_pkg::OpWalkAdd: begin
          total_q <= total_q + 16'(pcnt_q);
          curcnt_q <= curcnt_q + pcnt_q;
          p_q <= plink_q;
        end
        sads_pkg::OpReadQ: q_q <= edge_q;
        sads_pkg::OpCloneInit: begin
          n_q <= used_q;
          used_q <= used_q + 1'b1;
          col_q <= '0;
          ncnt_q <= '0;
        end
        sads_pkg::OpCopyRow: begin
          if (!col_q[sads_pkg::SymbolBits]) begin
            copy_col_q <= col_q[sads_pkg::SymbolBits-1:0];
            col_q <= col_q + 1'b1;
          end
        end
        sads_pkg::OpRedirect: begin
          ncnt_q <= ncnt_q + pcnt_q;
          p_q <= plink_q;
        end
        sads_pkg::OpFinish: last_q <= cur_q;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/sads_ctrl.sv =====
module sads_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             symbol_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   out_full_o,
  output sads_pkg::cmd_t         cmd_o,
  input  sads_pkg::status_t      status_i
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StInit = 4'd1;
  localparam logic [3:0] StIdle = 4'd2;
  localparam logic [3:0] StLoad = 4'd3;
  localparam logic [3:0] StWait = 4'd4;
  localparam logic [3:0] StWalk = 4'd5;
  localparam logic [3:0] StQWait = 4'd6;
  localparam logic [3:0] StQChk = 4'd7;
  localparam logic [3:0] StCopy = 4'd8;
  localparam logic [3:0] StRWait = 4'd9;
  localparam logic [3:0] StRedir = 4'd10;
  localparam logic [3:0] StDone = 4'd11;
  localparam logic [3:0] StPrep = 4'd12;

  logic [3:0] state_q, state_d;
  logic [sads_pkg::SymbolBits-1:0] sym_q;
  logic out_valid_q, full_q;
  logic accept, out_free;
  logic [1:0] wait_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == StIdle && out_free);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_full_o = full_q;

  always_comb begin
    state_d = state_q;
    cmd_o.op = sads_pkg::OpNone;
    cmd_o.sym = sym_q;
    case (state_q)
      StClear: begin
        cmd_o.op = sads_pkg::OpClearRow;
        if (status_i.clear_done) begin
          cmd_o.op = sads_pkg::OpNone;
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.op = sads_pkg::OpInit;
        state_d = StIdle;
      end
      StIdle: begin
        if (accept && !status_i.full) begin
          state_d = StPrep;
        end
      end
      StPrep: state_d = StLoad;
      StLoad: begin
        cmd_o.op = sads_pkg::OpNewCur;
        state_d = StWait;
      end
      StWait: begin
        if (wait_q == 2'd0) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (status_i.edge_empty) begin
          cmd_o.op = sads_pkg::OpWalkAdd;
          state_d = status_i.p_has_link ? StWait : StDone;
        end else begin
          cmd_o.op = sads_pkg::OpReadQ;
          state_d = StQWait;
        end
      end
      StQWait: begin
        if (wait_q == 2'd0) begin
          state_d = StQChk;
        end
      end
      StQChk: begin
        if (status_i.len_ok) begin
          cmd_o.op = sads_pkg::OpSetLinkQ;
          state_d = StDone;
        end else begin
          cmd_o.op = sads_pkg::OpCloneInit;
          state_d = StCopy;
        end
      end
      StCopy: begin
        cmd_o.op = sads_pkg::OpCopyRow;
        if (status_i.copy_done) begin
          cmd_o.op = sads_pkg::OpNone;
          state_d = StRWait;
        end
      end
      StRWait: begin
        if (wait_q == 2'd0) begin
          state_d = StRedir;
        end
      end
      StRedir: begin
        if (status_i.edge_is_q) begin
          cmd_o.op = sads_pkg::OpRedirect;
          state_d = status_i.p_has_link ? StRWait : StDone;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        cmd_o.op = sads_pkg::OpFinish;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      sym_q <= '0;
      out_valid_q <= 1'b0;
      full_q <= 1'b0;
      wait_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        wait_q <= 2'd1;
      end else if (wait_q != 2'd0) begin
        wait_q <= wait_q - 1'b1;
      end
      if (accept) begin
        sym_q <= symbol_i[sads_pkg::SymbolBits-1:0];
      end
      if (accept && status_i.full) begin
        out_valid_q <= 1'b1;
        full_q <= 1'b1;
      end else if (state_q == StDone) begin
        out_valid_q <= 1'b1;
        full_q <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/suffix_automaton_distinct_substrings.sv =====
// Counts the distinct nonempty substrings of the byte string received so far with an online
// suffix automaton; each request carries one symbol and yields one result. After reset the
// block clears its transition table, 2 * MAX_LEN * 256 entries, and takes no request until
// the clear is done. After acceptance a symbol adds a new state and walks the suffix links,
// adding an edge at each state passed, until the walk meets an existing edge or runs out of
// links. If that edge's target has the right length it becomes the suffix link, else it is
// cloned, its row copied one entry per cycle, and walk edges redirected to it. The next
// request can be taken in the cycle its predecessor's result is taken. Once MAX_LEN symbols
// have been taken, further symbols repeat the count with full_res_o set; the result is
// valid the cycle after acceptance; such requests are accepted each cycle unless stalled.
module suffix_automaton_distinct_substrings (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] distinct_count_o,
  output logic        full_res_o
);

  sads_pkg::cmd_t    cmd;
  sads_pkg::status_t status;
  logic [15:0]       total;

  sads_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_full_o  (full_res_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  sads_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .total_o  (total)
  );

  assign distinct_count_o = total;

endmodule

// ===== src/sads_checker.sv =====
module sads_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [15:0] distinct_count_i,
  input logic        full_res_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(distinct_count_i)
      && $stable(full_res_i))
    else $error("Stalled result changed.");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |-> in_stall_i)
    else $error("Request taken while a result was stalled.");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && full_res_i |=> $stable(distinct_count_i))
    else $error("Count changed after capacity was reached.");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> out_valid_i || in_stall_i)
    else $error("Request taken with neither a result nor a stall following.");

endmodule

bind suffix_automaton_distinct_substrings sads_assert u_sads_assert (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .distinct_count_i (distinct_count_o),
  .full_res_i       (full_res_o)
);
